@@ design/kda_pkg.sv @@
// kda_pkg: shared types and constants for the key debouncer with auto-repeat
// used by kda_lane and keypad_debounce_autorepeat_top
package kda_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic [1:0] EV_UP    = 2'd1;
  localparam logic [1:0] EV_DOWN  = 2'd2;
  localparam logic [1:0] EV_PRESS = 2'd3;

  localparam int CNT_W = 7;

  localparam logic [2:0] CFG_ACTIVE   = 3'd0;
  localparam logic [2:0] CFG_KEYS     = 3'd1;
  localparam logic [2:0] CFG_SCAN     = 3'd2;
  localparam logic [2:0] CFG_CHECKS   = 3'd3;
  localparam logic [2:0] CFG_DELAY    = 3'd4;
  localparam logic [2:0] CFG_INTERVAL = 3'd5;

  // per-key status word
  typedef struct packed {
    logic             held;
    logic [CNT_W-1:0] cnt;
  } key_stat_t;

  // what one lane found during a scan
  typedef struct packed {
    logic      ev_up;
    logic      ev_down;
    key_stat_t nxt;
  } lane_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POST,
    ST_OUT
  } state_t;

endpackage

@@ design/kda_lane.sv @@
// kda_lane: debounce core for one key, pure combinational step
// depends on kda_pkg
module kda_lane (
  input  kda_pkg::key_stat_t            stat,
  input  logic                          act,
  input  logic [kda_pkg::CNT_W-1:0]     checks,
  output kda_pkg::lane_res_t            res
);
  logic [kda_pkg::CNT_W:0] inc;

  // held keys count down on inactive scans, released keys count up
  always_comb begin
    inc = {1'b0, stat.cnt} + 1'b1;
    res = '0;
    if (stat.held) begin
      if (act) begin
        res.nxt = '{held: 1'b1, cnt: checks};
      end else if (stat.cnt <= 1) begin
        res.ev_up = 1'b1;
        res.nxt   = '0;
      end else begin
        res.nxt = '{held: 1'b1, cnt: stat.cnt - 1'b1};
      end
    end else begin
      if (act && inc >= {1'b0, checks}) begin
        res.ev_down = 1'b1;
        res.nxt     = '{held: 1'b1, cnt: checks};
      end else if (act) begin
        res.nxt = '{held: 1'b0, cnt: inc[kda_pkg::CNT_W-1:0]};
      end else begin
        res.nxt = '0;
      end
    end
  end
endmodule

@@ design/kda_merge.sv @@
// kda_merge: picks the lowest pending key event from the lane results
// uses no package
module kda_merge #(
  parameter int N = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  pend,
  output logic          any,
  output logic [IW-1:0] idx
);
  // priority pick, lowest index first
  always_comb begin
    any = 1'b0;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (pend[i]) begin
        any = 1'b1;
        idx = IW'(i);
      end
    end
  end
endmodule

@@ design/keypad_debounce_autorepeat_top.sv @@
// keypad_debounce_autorepeat_top: key debouncer, auto-repeat timers, message ring
// depends on kda_pkg, kda_lane, kda_merge
//
// Input channel in_*: one word per item. in_tuser is the kind (tick, pop,
// flush); in_tdata carries key_levels and key_select. Output channel out_*:
// exactly one result word per input word. Configuration is written through
// cfg_we/cfg_idx/cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. On a tick that ends a scan period, the
// lanes of the configured keys evaluate in parallel; the key events they found are then posted
// into the ring one message per cycle in key order, lowest key first, by a
// sequencer (each DOWN is followed by its PRESS), then a possible repeat PRESS.
// The ring is a QUEUE_DEPTH-entry memory that drops its oldest message when
// full. A result waits in the output register while out_tready is low; a new
// item is taken once that register is free. Reset clears key status, ring
// pointers and timers; the scan timer runs from reset.
module keypad_debounce_autorepeat_top #(
  parameter int MAX_KEYS    = 16,
  parameter int QUEUE_DEPTH = 32,
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_levels[15:0], key_select[19:16], zero pad
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // message[7:0], message_valid[8], key_is_down[9],
                                  // pressed_mask[25:10], queued_count[30:26], pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = kda_pkg::CNT_W;

  // configuration registers
  logic             active_r;
  logic [4:0]       keys_r;
  logic [15:0]      scan_r, delay_r, intv_r;
  logic [CW-1:0]    checks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0; keys_r <= 5'd16; scan_r <= 16'd30;
      checks_r <= 7'd3; delay_r <= 16'd500; intv_r <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_idx)
        kda_pkg::CFG_ACTIVE:   active_r <= cfg_data[0];
        kda_pkg::CFG_KEYS:     keys_r   <= cfg_data[4:0];
        kda_pkg::CFG_SCAN:     scan_r   <= cfg_data;
        kda_pkg::CFG_CHECKS:   checks_r <= cfg_data[CW-1:0];
        kda_pkg::CFG_DELAY:    delay_r  <= cfg_data;
        kda_pkg::CFG_INTERVAL: intv_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [TIMER_WIDTH-1:0] scan_p, delay_p, intv_p;
  logic [CW-1:0] checks_e;
  logic [6:0]    nkeys;
  always_comb begin
    scan_p  = TIMER_WIDTH'(scan_r);
    delay_p = TIMER_WIDTH'(delay_r);
    intv_p  = TIMER_WIDTH'(intv_r);
    if (scan_p == '0)  scan_p  = TIMER_WIDTH'(1);
    if (delay_p == '0) delay_p = TIMER_WIDTH'(1);
    if (intv_p == '0)  intv_p  = TIMER_WIDTH'(1);
    checks_e = (checks_r == '0) ? CW'(1) : checks_r;
    nkeys = ({2'b0, keys_r} > 7'(MAX_KEYS)) ? 7'(MAX_KEYS) : {2'b0, keys_r};
  end

  // state
  kda_pkg::state_t state_r, state_nxt;
  kda_pkg::key_stat_t stat_r [MAX_KEYS];
  logic [MAX_KEYS-1:0] up_r, down_r;      // pending events from the scan
  logic                press_pend_r;      // second message of a down
  logic [KW-1:0]       cur_r;
  logic                rep_pend_r;
  logic [QW-1:0]       head_r, tail_r;
  logic [5:0]          last_r;
  logic [4:0]          held_r;
  logic [TIMER_WIDTH-1:0] st_cnt_r, dl_cnt_r, iv_cnt_r;
  logic                dl_run_r, iv_run_r;
  logic [1:0]          kind_r;
  logic [3:0]          sel_r;
  logic [7:0]          msg_r;
  logic                mval_r;
  logic [7:0]          ring [QUEUE_DEPTH];
  logic [7:0]          rd_q;

  // lanes
  kda_pkg::lane_res_t res [MAX_KEYS];
  logic [MAX_KEYS-1:0] act;
  genvar g;
  generate
    for (g = 0; g < MAX_KEYS; g++) begin : g_lane
      assign act[g] = ((g < 16) ? in_tdata[g % 16] : 1'b0) == active_r;
      kda_lane u_lane (.stat(stat_r[g]), .act(act[g]), .checks(checks_e), .res(res[g]));
    end
  endgenerate

  logic          any;
  logic [KW-1:0] pidx;
  kda_merge #(.N(MAX_KEYS), .IW(KW)) u_merge (.pend(up_r | down_r), .any(any), .idx(pidx));

  wire acc = in_tvalid && in_tready;
  assign in_tready = (state_r == kda_pkg::ST_IDLE);

  // timer counting for a tick
  logic [TIMER_WIDTH:0] st_inc, dl_inc, iv_inc;
  logic st_fire, dl_fire, iv_fire;
  always_comb begin
    st_inc = {1'b0, st_cnt_r} + 1'b1;
    dl_inc = {1'b0, dl_cnt_r} + 1'b1;
    iv_inc = {1'b0, iv_cnt_r} + 1'b1;
    st_fire = st_inc >= {1'b0, scan_p};
    dl_fire = dl_run_r && dl_inc >= {1'b0, delay_p};
    iv_fire = iv_run_r && iv_inc >= {1'b0, intv_p};
  end

  // message post sequencer
  logic       post;
  logic [1:0] pev;
  logic [5:0] pkey;
  always_comb begin
    state_nxt = state_r;
    post = 1'b0; pev = kda_pkg::EV_PRESS; pkey = last_r;
    case (state_r)
      kda_pkg::ST_IDLE: if (acc) state_nxt = (in_tuser == kda_pkg::KIND_TICK) ?
                                  kda_pkg::ST_POST : kda_pkg::ST_OUT;
      kda_pkg::ST_POST: begin
        if (press_pend_r) begin
          post = 1'b1; pev = kda_pkg::EV_PRESS; pkey = 6'(cur_r);
        end else if (any) begin
          post = 1'b1; pkey = 6'(pidx);
          pev = down_r[pidx] ? kda_pkg::EV_DOWN : kda_pkg::EV_UP;
        end else if (rep_pend_r) begin
          post = 1'b1;
        end else begin
          state_nxt = kda_pkg::ST_OUT;
        end
      end
      kda_pkg::ST_OUT: if (out_tready) state_nxt = kda_pkg::ST_IDLE;
      default: state_nxt = kda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kda_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ring memory and read
  always_ff @(posedge clk) begin
    if (post) ring[head_r] <= {pev, pkey};
    rd_q <= ring[tail_r];
  end

  logic [4:0] held_up;
  assign held_up = held_r + 5'd1;

  // repeat timers are touched by a down, by release of the repeating key
  // or when several keys are held
  logic hold_many, tm_hit;
  assign hold_many = (pev == kda_pkg::EV_DOWN) ? (held_up > 5'd1) : (held_r > 5'd1);
  assign tm_hit    = (pev == kda_pkg::EV_DOWN) || hold_many ||
                     (pev == kda_pkg::EV_UP && pkey == last_r);

  // datapath and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KEYS; i++) stat_r[i] <= '0;
      up_r <= '0; down_r <= '0; press_pend_r <= 1'b0; rep_pend_r <= 1'b0;
      head_r <= '0; tail_r <= '0; last_r <= '0; held_r <= '0;
      st_cnt_r <= '0; dl_cnt_r <= '0; iv_cnt_r <= '0;
      dl_run_r <= 1'b0; iv_run_r <= 1'b0; mval_r <= 1'b0; cur_r <= '0;
    end else begin
      if (acc) begin
        kind_r <= in_tuser;
        sel_r  <= in_tdata[19:16];
        mval_r <= 1'b0;
        msg_r  <= '0;
        case (in_tuser)
          kda_pkg::KIND_TICK: begin
            st_cnt_r <= st_fire ? '0 : st_inc[TIMER_WIDTH-1:0];
            if (dl_run_r) dl_cnt_r <= dl_fire ? '0 : dl_inc[TIMER_WIDTH-1:0];
            if (iv_run_r) iv_cnt_r <= iv_fire ? '0 : iv_inc[TIMER_WIDTH-1:0];
            rep_pend_r <= iv_fire;
            if (dl_fire) begin
              dl_run_r <= 1'b0; dl_cnt_r <= '0;
              iv_run_r <= 1'b1; iv_cnt_r <= '0;
            end
            if (st_fire) begin
              for (int i = 0; i < MAX_KEYS; i++) begin
                if (7'(i) < nkeys) begin
                  stat_r[i] <= res[i].nxt;
                  up_r[i]   <= res[i].ev_up;
                  down_r[i] <= res[i].ev_down;
                end
              end
            end
          end
          kda_pkg::KIND_POP: if (head_r != tail_r) begin
            mval_r <= 1'b1;
            tail_r <= tail_r + 1'b1;
          end
          kda_pkg::KIND_FLUSH: begin
            head_r <= '0; tail_r <= '0;
            dl_run_r <= 1'b0; dl_cnt_r <= '0;
            iv_run_r <= 1'b0; iv_cnt_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == kda_pkg::ST_OUT && mval_r && kind_r == kda_pkg::KIND_POP &&
          msg_r == '0)
        msg_r <= rd_q;
      if (post) begin
        head_r <= head_r + 1'b1;
        if (head_r + 1'b1 == tail_r) tail_r <= tail_r + 1'b1;
        if (press_pend_r) begin
          press_pend_r <= 1'b0;
        end else if (any) begin
          up_r[pidx] <= 1'b0; down_r[pidx] <= 1'b0;
          if (down_r[pidx]) begin
            press_pend_r <= 1'b1; cur_r <= pidx;
          end
        end
        // held count moves before a down posts, after an up posts
        if (!press_pend_r && any && down_r[pidx]) held_r <= held_up;
        if (!press_pend_r && any && !down_r[pidx] && held_r != 0) held_r <= held_r - 1'b1;
        if (pev == kda_pkg::EV_DOWN) last_r <= pkey;
        if (pev == kda_pkg::EV_DOWN && !hold_many) begin
          dl_run_r <= 1'b1; dl_cnt_r <= '0;
          iv_run_r <= 1'b0; iv_cnt_r <= '0;
        end else if (tm_hit) begin
          dl_run_r <= 1'b0; dl_cnt_r <= '0;
          iv_run_r <= 1'b0; iv_cnt_r <= '0;
        end
        // the repeat post, or a stopped interval timer, drops the pending repeat
        if (tm_hit || (!press_pend_r && !any)) rep_pend_r <= 1'b0;
      end
    end
  end

  // result word
  logic [15:0]     mask;
  logic            kdown;
  logic [QW-1:0]   qcnt;
  always_comb begin
    mask = '0;
    for (int i = 0; i < MAX_KEYS && i < 16; i++) mask[i] = stat_r[i].held;
    kdown = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++)
      if (4'(i) == sel_r && i < 16) kdown = stat_r[i].held;
    if ({3'b0, sel_r} >= nkeys) kdown = 1'b0;
    qcnt = head_r - tail_r;
  end

  logic [7:0] msg_o;
  assign msg_o = (mval_r && msg_r == '0) ? rd_q : msg_r;
  assign out_tvalid = (state_r == kda_pkg::ST_OUT);
  assign out_tdata  = {1'b0, 5'(qcnt), mask, kdown, mval_r, mval_r ? msg_o : 8'd0};

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid) else $error("result repeated");
  a_no_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
    post |-> state_r == kda_pkg::ST_POST) else $error("post outside scan");
endmodule
